// ===== design/ilie_pkg.sv =====
// Shared types and codes for the indexed list with positional insert and erase.
`default_nettype none

package ilie_pkg;

    // Fixed field widths of the request and response words
    localparam int CMD_W   = 2;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Front and back read value of an empty list
    localparam logic signed [DATA_W-1:0] EMPTY_READ = -32'sd1;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] last_value;
    } rsp_word_t;

    // Per-cycle operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD   = 2'b00,
        OP_INSERT = 2'b01,
        OP_ERASE  = 2'b10
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/ilie_cell.sv =====
// One list cell: holds a single entry and shifts with its neighbours.
`default_nettype none

module ilie_cell
    import ilie_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
)
(
    input  wire logic                     clk,
    input  wire cell_ctl_t                ctl,
    input  wire logic [IDX_W-1:0]         target,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0]      data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // On insert: value at target, left above it; on erase: right from target up
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (MY_IDX > target)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == target)
                begin
                    data_next = ctl.value;
                end
            end
            OP_ERASE:
            begin
                if (MY_IDX >= target)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== design/ilie_ctrl.sv =====
// Command decode: range and capacity checks, new count and cell operation.
`default_nettype none

module ilie_ctrl
    import ilie_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
)
(
    input  wire req_word_t          req,
    input  wire logic [CNT_W-1:0]   used,
    output logic [STAT_W-1:0]       status,
    output logic [CNT_W-1:0]        used_next,
    output cell_ctl_t               ctl,
    output logic [IDX_W-1:0]        target
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] used_c;
    logic             full;

    assign pos_c  = CMP_W'(req.position);
    assign used_c = CMP_W'(used);
    assign full   = (used == CAP_CNT);

    // Check range first, then room; drop the command on any refusal
    always_comb
    begin
        status    = ST_DONE;
        used_next = used;
        ctl.op    = OP_HOLD;
        ctl.value = req.value;
        target    = IDX_W'(req.position);
        case (req.cmd)
            CMD_APPEND:
            begin
                target = IDX_W'(used);
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.op    = OP_INSERT;
                    used_next = used + CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (pos_c > used_c)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.op    = OP_INSERT;
                    used_next = used + CNT_W'(1);
                end
            end
            CMD_ERASE:
            begin
                if (pos_c >= used_c)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctl.op    = OP_ERASE;
                    used_next = used - CNT_W'(1);
                end
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/indexed_list_insert_erase.sv =====
// Top level of the indexed list: cell row, command decode and response register.
//
//   channel | direction | word        | handshake
//   --------+-----------+-------------+----------------------
//   req     | in        | req_word_t  | req_valid / req_stall
//   rsp     | out       | rsp_word_t  | rsp_valid / rsp_stall
//
// A command updates the whole cell row when it is accepted; its response word is formed
// from the updated row in the following cycle, so one command per cycle is sustained
// while rsp_stall is low, and rsp_valid rises once that word is in the output register.
// Reset empties the list at once; entries themselves are not cleared.
// req_stall rises only while a formed response cannot leave the output register.
`default_nettype none

module indexed_list_insert_erase
    import ilie_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  used_next;
    logic              pend_reg;
    logic              pend_next;
    logic [STAT_W-1:0] pend_status_reg;
    logic [STAT_W-1:0] pend_status_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_word_t         out_word_reg;
    rsp_word_t         out_word_next;

    logic              req_acc;
    logic              load;
    logic [STAT_W-1:0] dec_status;
    logic [CNT_W-1:0]  dec_used;
    cell_ctl_t         dec_ctl;
    cell_ctl_t         cell_ctl;
    logic [IDX_W-1:0]  dec_target;
    logic              empty;
    logic signed [DATA_W-1:0] last_sel;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    // Move the pending response out when the output register is free
    assign load      = pend_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = pend_reg && !load;
    assign req_acc   = req_valid && !req_stall;

    ilie_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .req       (req),
        .used      (used_reg),
        .status    (dec_status),
        .used_next (dec_used),
        .ctl       (dec_ctl),
        .target    (dec_target)
    );

    // Hold the row unless a command is taken this cycle
    always_comb
    begin
        cell_ctl = dec_ctl;
        if (!req_acc)
        begin
            cell_ctl.op = OP_HOLD;
        end
    end

    // Row of cells, each fed by its neighbours, with zero beyond either end
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ilie_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .target     (dec_target),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    // Pick the tail entry: each cell gated by its own tail match
    always_comb
    begin
        last_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (used_reg == CNT_W'(i + 1))
            begin
                last_sel = last_sel | cell_data[i];
            end
        end
    end

    assign empty = (used_reg == '0);

    // Form the response word from the updated row
    always_comb
    begin
        out_word_next             = out_word_reg;
        out_word_next.status      = pend_status_reg;
        out_word_next.count       = COUNT_W'(used_reg);
        out_word_next.is_empty    = empty;
        out_word_next.first_value = empty ? EMPTY_READ : cell_data[0];
        out_word_next.last_value  = empty ? EMPTY_READ : last_sel;
    end

    // Advance count, pending flag and output valid
    always_comb
    begin
        used_next        = req_acc ? dec_used : used_reg;
        pend_status_next = req_acc ? dec_status : pend_status_reg;
        pend_next        = req_acc ? 1'b1 : (load ? 1'b0 : pend_reg);
        out_valid_next   = load ? 1'b1 : (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        if (load)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

endmodule

`default_nettype wire

// ===== design/ilie_checker.sv =====
// Port-level checks of the indexed list and their bind to the top level.
`default_nettype none

module ilie_checker
    import ilie_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rsp_valid,
    input wire logic      rsp_stall,
    input wire rsp_word_t rsp
);

    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);
    localparam logic               SMALL   = (CAPACITY < 32);

    // A stalled response word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    // Empty flag agrees with the count, checked while the capacity is below 32
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("empty flag disagrees with count");

    // An empty list reads minus one at both ends
    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |->
            (rsp.first_value == EMPTY_READ) && (rsp.last_value == EMPTY_READ))
        else $error("empty list front or back not minus one");

    // A full refusal reports a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |->
            (rsp.count == CAP_CNT) && !rsp.is_empty)
        else $error("full status without full count");

    // A single entry is both front and back, checked while the capacity is below 32
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL && rsp.count == COUNT_W'(1) |->
            rsp.first_value == rsp.last_value)
        else $error("single entry front and back differ");

endmodule

bind indexed_list_insert_erase ilie_checker #(
    .CAPACITY (CAPACITY)
) u_ilie_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
